@@ rtl/bdcd_pkg.sv @@
`timescale 1ns / 1ps
// bdcd_pkg: shared types and constants of the button debounce and click detector
// no dependencies; used by the interfaces, the event core and the top level
package bdcd_pkg;

  // field widths of the poll and event transactions
  localparam int unsigned NOW_BITS  = 32;
  localparam int unsigned CODE_BITS = 3;
  localparam int unsigned MS_BITS   = 16;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ACTIVE_LOW   = 3'd0,
    CFG_DEBOUNCE     = 3'd1,
    CFG_LONG_PRESS   = 3'd2,
    CFG_CLICK        = 3'd3,
    CFG_DOUBLE_CLICK = 3'd4,
    CFG_LONG_EN      = 3'd5,
    CFG_DOUBLE_EN    = 3'd6
  } cfg_idx_e;

  // event codes
  typedef enum logic [CODE_BITS-1:0] {
    EV_PRESSED  = 3'd0,
    EV_RELEASED = 3'd1,
    EV_CLICK    = 3'd2,
    EV_DOUBLE   = 3'd3,
    EV_LONG     = 3'd4
  } event_e;

  // configuration register set
  typedef struct packed {
    logic               active_low;
    logic [MS_BITS-1:0] debounce_ms;
    logic [MS_BITS-1:0] long_press_ms;
    logic [MS_BITS-1:0] click_ms;
    logic [MS_BITS-1:0] double_click_ms;
    logic               long_press_enable;
    logic               double_click_enable;
  } cfg_t;

  // one poll of the pin
  typedef struct packed {
    logic                pin_level;
    logic [NOW_BITS-1:0] now_ms;
  } poll_t;

  // events produced by one poll, first in code0
  typedef struct packed {
    logic [1:0] count;
    event_e     code0;
    event_e     code1;
    logic       held;
  } res_t;

endpackage

@@ rtl/bdcd_if.sv @@
`timescale 1ns / 1ps
// bdcd_poll_if and bdcd_event_if: valid/ready channels of the detector
// depends on bdcd_pkg for field widths

interface bdcd_poll_if;
  logic                          valid;
  logic                          ready;
  logic                          pin_level;
  logic [bdcd_pkg::NOW_BITS-1:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdcd_event_if;
  logic                           valid;
  logic                           ready;
  logic [bdcd_pkg::CODE_BITS-1:0] event_code;
  logic                           held_now;
  logic                           last_of_run;

  modport source (output valid, output event_code, output held_now, output last_of_run,
                  input ready);
  modport sink   (input valid, input event_code, input held_now, input last_of_run,
                  output ready);
endinterface

@@ rtl/button_debounce_click_detector.sv @@
`timescale 1ns / 1ps
// button_debounce_click_detector: top level with config registers, poll register,
// event core and event queue; depends on bdcd_pkg, bdcd_if.sv and bdcd_core
//
//   channel   dir  handshake      payload
//   poll_i    in   valid/ready    pin_level, now_ms
//   event_o   out  valid/ready    event_code, held_now, last_of_run
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// a poll is registered, decided once two queue entries are free, and its zero to
// two events go to a four-entry queue, drained one event per cycle while ready
// a poll can be taken every cycle while the queue has two free entries, so a poll
// that gives two events takes two event slots of output bandwidth
// reset (async, active low) sets register defaults, clears all but queue/poll data
// a stalled event output blocks new polls once fewer than two queue entries are free
module button_debounce_click_detector #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bdcd_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [bdcd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  bdcd_poll_if.sink                           poll_i,
  bdcd_event_if.source                        event_o
);
  import bdcd_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR   = $clog2(QDEPTH);
  localparam int unsigned QCNT   = $clog2(QDEPTH + 1);

  typedef struct packed {
    event_e code;
    logic   held;
    logic   last;
  } qent_t;

  cfg_t             cfg_q;
  logic             in_valid_q;
  poll_t            in_item_q;
  poll_t            poll_item;
  logic             fire;
  res_t             res;
  qent_t            queue_q [QDEPTH];
  logic [QPTR-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR-1:0]  wr_ptr_nx;
  logic [QCNT-1:0]  count_q;
  logic             pop;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low          <= 1'b1;
      cfg_q.debounce_ms         <= MS_BITS'(50);
      cfg_q.long_press_ms       <= MS_BITS'(1000);
      cfg_q.click_ms            <= MS_BITS'(500);
      cfg_q.double_click_ms     <= MS_BITS'(300);
      cfg_q.long_press_enable   <= 1'b1;
      cfg_q.double_click_enable <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_LOW:   cfg_q.active_low          <= cfg_data_i[0];
        CFG_DEBOUNCE:     cfg_q.debounce_ms         <= cfg_data_i[MS_BITS-1:0];
        CFG_LONG_PRESS:   cfg_q.long_press_ms       <= cfg_data_i[MS_BITS-1:0];
        CFG_CLICK:        cfg_q.click_ms            <= cfg_data_i[MS_BITS-1:0];
        CFG_DOUBLE_CLICK: cfg_q.double_click_ms     <= cfg_data_i[MS_BITS-1:0];
        CFG_LONG_EN:      cfg_q.long_press_enable   <= cfg_data_i[0];
        CFG_DOUBLE_EN:    cfg_q.double_click_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // poll register, emptied when the queue has room for two events
  assign fire         = in_valid_q && (count_q <= QCNT'(QDEPTH - 2));
  assign poll_i.ready = !in_valid_q || fire;
  assign poll_item.pin_level = poll_i.pin_level;
  assign poll_item.now_ms    = poll_i.now_ms;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      in_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.valid && poll_i.ready) begin
      in_item_q <= poll_item;
    end
  end

  // event decision
  bdcd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (fire),
    .poll_i (in_item_q),
    .res_o  (res)
  );

  // event queue
  assign pop       = event_o.valid && event_o.ready;
  assign wr_ptr_nx = wr_ptr_q + QPTR'(1);

  always_ff @(posedge clk_i) begin
    if (fire && res.count != 2'd0) begin
      queue_q[wr_ptr_q] <= '{code: res.code0, held: res.held, last: res.count == 2'd1};
    end
    if (fire && res.count == 2'd2) begin
      queue_q[wr_ptr_nx] <= '{code: res.code1, held: res.held, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= wr_ptr_q + QPTR'(res.count);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR'(1);
      end
      count_q <= count_q + (fire ? QCNT'(res.count) : QCNT'(0)) - QCNT'(pop);
    end
  end

  assign event_o.valid       = count_q != '0;
  assign event_o.event_code  = queue_q[rd_ptr_q].code;
  assign event_o.held_now    = queue_q[rd_ptr_q].held;
  assign event_o.last_of_run = queue_q[rd_ptr_q].last;

  // checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT'(QDEPTH))
    else $error("event queue count above depth");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> res.count != 2'd3)
    else $error("more than two events from one poll");

  a_run_partner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && !event_o.last_of_run) |-> count_q >= QCNT'(2))
    else $error("first event of a pair without its partner queued");

  a_no_fire_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> in_valid_q)
    else $error("poll decided without a registered transaction");

endmodule

@@ rtl/bdcd_core.sv @@
`timescale 1ns / 1ps
// bdcd_core: debounce state and event decision, one poll per cycle while fire_i
// depends on bdcd_pkg (cfg_t, poll_t, res_t, event_e)
module bdcd_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdcd_pkg::cfg_t  cfg_i,
  input  logic            fire_i,
  input  bdcd_pkg::poll_t poll_i,
  output bdcd_pkg::res_t  res_o
);
  import bdcd_pkg::*;

  // state
  logic                 started_q, started_d;
  logic                 raw_prev_q, raw_prev_d;
  logic                 held_q, held_d;
  logic                 long_rep_q, long_rep_d;
  logic [TIME_BITS-1:0] change_q, change_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic [TIME_BITS-1:0] release_q, release_d;

  // datapath
  logic                 level;
  logic                 changed;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] since_release;
  logic                 accept_edge;
  logic                 press_ev;
  logic                 release_ev;
  logic                 click_ev;
  logic                 long_ev;
  logic                 long_rep_eff;
  logic                 long_due;

  assign now_t = TIME_BITS'(poll_i.now_ms);
  assign level = poll_i.pin_level ^ cfg_i.active_low;

  // wrapped time differences against the stored stamps
  assign since_change  = now_t - change_q;
  assign since_press   = now_t - press_q;
  assign since_release = now_t - release_q;

  // a level change restarts the timer, so only an unchanged level can be accepted
  assign changed     = level != raw_prev_q;
  assign accept_edge = started_q && !changed && (level != held_q) &&
                       (since_change > TIME_BITS'(cfg_i.debounce_ms));
  assign press_ev    = accept_edge && level;
  assign release_ev  = accept_edge && !level;

  // release after a short press gives a click; a long hold gives nothing extra
  assign click_ev = release_ev &&
                    !(cfg_i.long_press_enable &&
                      since_press >= TIME_BITS'(cfg_i.long_press_ms)) &&
                    (since_press < TIME_BITS'(cfg_i.click_ms));

  // long press timed from the new press when it happens in this poll
  assign long_rep_eff = press_ev ? 1'b0 : long_rep_q;
  assign long_due     = press_ev ? (cfg_i.long_press_ms == '0)
                                 : (since_press >= TIME_BITS'(cfg_i.long_press_ms));
  assign long_ev      = started_q && cfg_i.long_press_enable &&
                        (press_ev || (held_q && !release_ev)) &&
                        !long_rep_eff && long_due;

  // next state
  always_comb begin
    started_d  = started_q;
    raw_prev_d = raw_prev_q;
    held_d     = held_q;
    long_rep_d = long_rep_q;
    change_d   = change_q;
    press_d    = press_q;
    release_d  = release_q;
    if (!started_q) begin
      started_d  = 1'b1;
      raw_prev_d = level;
      held_d     = level;
    end else begin
      raw_prev_d = level;
      if (changed) begin
        change_d = now_t;
      end
      if (accept_edge) begin
        held_d = level;
      end
      if (press_ev) begin
        press_d = now_t;
      end
      if (release_ev) begin
        release_d = now_t;
      end
      if (long_ev) begin
        long_rep_d = 1'b1;
      end else if (press_ev) begin
        long_rep_d = 1'b0;
      end
    end
  end

  // result list for this poll
  always_comb begin
    res_o.held  = held_d;
    res_o.count = 2'd0;
    res_o.code0 = EV_PRESSED;
    res_o.code1 = EV_LONG;
    if (press_ev) begin
      res_o.code0 = EV_PRESSED;
      res_o.code1 = EV_LONG;
      res_o.count = long_ev ? 2'd2 : 2'd1;
    end else if (release_ev) begin
      res_o.code0 = EV_RELEASED;
      res_o.code1 = (cfg_i.double_click_enable &&
                     since_release < TIME_BITS'(cfg_i.double_click_ms)) ? EV_DOUBLE
                                                                        : EV_CLICK;
      res_o.count = click_ev ? 2'd2 : 2'd1;
    end else if (long_ev) begin
      res_o.code0 = EV_LONG;
      res_o.count = 2'd1;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      raw_prev_q <= 1'b0;
      held_q     <= 1'b0;
      long_rep_q <= 1'b0;
      change_q   <= '0;
      press_q    <= '0;
      release_q  <= '0;
    end else if (fire_i) begin
      started_q  <= started_d;
      raw_prev_q <= raw_prev_d;
      held_q     <= held_d;
      long_rep_q <= long_rep_d;
      change_q   <= change_d;
      press_q    <= press_d;
      release_q  <= release_d;
    end
  end

endmodule

@@ tb/sv/bdcd_tb_pkg.sv @@
`timescale 1ns / 1ps
// bdcd_tb_pkg: event scoreboard of the debounce and click detector testbench
// depends on bdcd_pkg for event codes, register indexes and field widths
package bdcd_tb_pkg;
  import bdcd_pkg::*;

  // one event the detector is expected to emit
  typedef struct {
    event_e code;
    logic   held;
    logic   last;
  } exp_event_t;

  class bdcd_event_book;
    // register copy
    logic                active_low;
    logic [MS_BITS-1:0]  debounce_ms;
    logic [MS_BITS-1:0]  long_press_ms;
    logic [MS_BITS-1:0]  click_ms;
    logic [MS_BITS-1:0]  double_click_ms;
    logic                long_en;
    logic                double_en;
    // detector state copy
    logic                started;
    logic                raw_prev;
    logic                held_level;
    logic                long_reported;
    logic [NOW_BITS-1:0] change_stamp;
    logic [NOW_BITS-1:0] press_stamp;
    logic [NOW_BITS-1:0] release_stamp;
    // events still owed by the detector, oldest first
    exp_event_t          pending_events[$];
    int unsigned         mismatches;

    function new();
      active_low      = 1'b1;
      debounce_ms     = 16'd50;
      long_press_ms   = 16'd1000;
      click_ms        = 16'd500;
      double_click_ms = 16'd300;
      long_en         = 1'b1;
      double_en       = 1'b1;
      started         = 1'b0;
      raw_prev        = 1'b0;
      held_level      = 1'b0;
      long_reported   = 1'b0;
      change_stamp    = '0;
      press_stamp     = '0;
      release_stamp   = '0;
      mismatches      = 0;
    endfunction

    // mirror a register write
    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_ACTIVE_LOW:   active_low      = data[0];
        CFG_DEBOUNCE:     debounce_ms     = data[MS_BITS-1:0];
        CFG_LONG_PRESS:   long_press_ms   = data[MS_BITS-1:0];
        CFG_CLICK:        click_ms        = data[MS_BITS-1:0];
        CFG_DOUBLE_CLICK: double_click_ms = data[MS_BITS-1:0];
        CFG_LONG_EN:      long_en         = data[0];
        CFG_DOUBLE_EN:    double_en       = data[0];
        default: ;
      endcase
    endfunction

    // predict the events of one accepted poll transaction
    function void note_poll(logic pin, logic [NOW_BITS-1:0] now);
      logic                lvl;
      logic [NOW_BITS-1:0] stable_for;
      logic [NOW_BITS-1:0] press_len;
      logic [NOW_BITS-1:0] since_release;
      logic [NOW_BITS-1:0] held_for;
      event_e              codes[$];
      exp_event_t          ev;
      lvl = pin ^ active_low;
      // first poll only loads the levels
      if (!started) begin
        raw_prev   = lvl;
        held_level = lvl;
        started    = 1'b1;
        return;
      end
      if (lvl != raw_prev) change_stamp = now;
      stable_for = now - change_stamp;
      // debounced level change
      if (stable_for > {16'd0, debounce_ms} && lvl != held_level) begin
        held_level = lvl;
        if (held_level) begin
          press_stamp   = now;
          long_reported = 1'b0;
          codes.push_back(EV_PRESSED);
        end else begin
          press_len     = now - press_stamp;
          since_release = now - release_stamp;
          codes.push_back(EV_RELEASED);
          // a long hold gives no click; a medium one gives nothing more
          if (!(long_en && press_len >= {16'd0, long_press_ms})) begin
            if (press_len < {16'd0, click_ms}) begin
              if (double_en && since_release < {16'd0, double_click_ms})
                codes.push_back(EV_DOUBLE);
              else
                codes.push_back(EV_CLICK);
            end
          end
          release_stamp = now;
        end
      end
      // long press, once per hold
      held_for = now - press_stamp;
      if (long_en && held_level && !long_reported && held_for >= {16'd0, long_press_ms}) begin
        long_reported = 1'b1;
        codes.push_back(EV_LONG);
      end
      raw_prev = lvl;
      foreach (codes[k]) begin
        ev.code = codes[k];
        ev.held = held_level;
        ev.last = (k == codes.size() - 1);
        pending_events.push_back(ev);
      end
    endfunction

    // compare one accepted event transaction with the oldest expectation
    function void check_event(logic [CODE_BITS-1:0] code, logic held, logic last);
      exp_event_t ev;
      if (pending_events.size() == 0) begin
        $error("unexpected event transaction: event_code %0d held_now %0b last_of_run %0b",
               code, held, last);
        mismatches++;
        return;
      end
      ev = pending_events.pop_front();
      if (code !== ev.code) begin
        $error("event_code: expected %0d, actual %0d", ev.code, code);
        mismatches++;
      end
      if (held !== ev.held) begin
        $error("held_now: expected %0b, actual %0b", ev.held, held);
        mismatches++;
      end
      if (last !== ev.last) begin
        $error("last_of_run: expected %0b, actual %0b", ev.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned pending_count();
      return pending_events.size();
    endfunction

    // expectations never met count as failures at the end
    function void flag_leftovers();
      if (pending_events.size() != 0) begin
        $error("%0d expected events never arrived", pending_events.size());
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: testbench of button_debounce_click_detector, directed then random polls
// depends on bdcd_pkg, bdcd_if.sv, the detector RTL and bdcd_tb_pkg
module tb_top;
  import bdcd_pkg::*;
  import bdcd_tb_pkg::*;

  localparam int unsigned POLLS_PER_PHASE = 175;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned SQUEEZE_CYCLES  = 120;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  bdcd_poll_if  poll_ch ();
  bdcd_event_if evt_ch ();

  bdcd_event_book      book;
  bit                  gaps_on;
  int unsigned         squeeze_req  = 0;
  int unsigned         squeeze_done = 0;
  logic [NOW_BITS-1:0] tcur;
  logic                cur_pin;

  button_debounce_click_detector dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .poll_i     (poll_ch),
    .event_o    (evt_ch)
  );

  always #10 clk = ~clk;

  // offer one poll transaction and wait until it is taken
  task automatic send_poll(input logic pin, input logic [NOW_BITS-1:0] now);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    poll_ch.valid     <= 1'b1;
    poll_ch.pin_level <= pin;
    poll_ch.now_ms    <= now;
    do @(posedge clk); while (!poll_ch.ready);
    book.note_poll(pin, now);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    book.write_reg(idx, data);
  endtask

  // stop offering, wait for every owed event, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    poll_ch.valid <= 1'b0;
    while (book.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic al, input int unsigned deb, input int unsigned lp,
                              input int unsigned ck, input int unsigned dc,
                              input logic len, input logic den);
    drain();
    cfg_write(CFG_ACTIVE_LOW, {15'd0, al});
    cfg_write(CFG_DEBOUNCE, deb[15:0]);
    cfg_write(CFG_LONG_PRESS, lp[15:0]);
    cfg_write(CFG_CLICK, ck[15:0]);
    cfg_write(CFG_DOUBLE_CLICK, dc[15:0]);
    cfg_write(CFG_LONG_EN, {15'd0, len});
    cfg_write(CFG_DOUBLE_EN, {15'd0, den});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly press/hold/release sequences with bounce, some noise polls
  task automatic run_phase(input int unsigned n, input int unsigned step_max,
                           input bit squeeze);
    int unsigned sent;
    int unsigned r;
    int unsigned bounces;
    int unsigned hold;
    bit          squeezed;
    sent     = 0;
    squeezed = 0;
    while (sent < n) begin
      if (squeeze && !squeezed && sent >= n / 3) begin
        squeeze_req++;
        squeezed = 1;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_poll(1'($urandom_range(0, 1)), $urandom);
        sent++;
      end else begin
        if (r < 75) cur_pin = ~cur_pin;
        bounces = $urandom_range(0, 3);
        repeat (bounces) begin
          tcur += $urandom_range(0, 2);
          send_poll(~cur_pin, tcur);
          tcur += $urandom_range(0, 2);
          send_poll(cur_pin, tcur);
          sent += 2;
        end
        hold = $urandom_range(1, 8);
        repeat (hold) begin
          tcur += $urandom_range(0, step_max);
          send_poll(cur_pin, tcur);
          sent++;
        end
      end
    end
  endtask

  // event sink with random back-pressure and an occasional long hold-off
  initial begin
    int unsigned hold;
    evt_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = gaps_on ? $urandom_range(0, 3) : 0;
      if (squeeze_done != squeeze_req) begin
        hold = SQUEEZE_CYCLES;
        squeeze_done++;
      end
      @(negedge clk);
      if (hold != 0) begin
        evt_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      evt_ch.ready <= 1'b1;
      do @(posedge clk); while (!evt_ch.valid);
      book.check_event(evt_ch.event_code, evt_ch.held_now, evt_ch.last_of_run);
    end
  end

  // main sequence
  initial begin
    int unsigned p;
    int unsigned deb;
    int unsigned lp;
    int unsigned ck;
    int unsigned dc;
    int unsigned top_ms;
    book              = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_ACTIVE_LOW;
    cfg_data          = '0;
    poll_ch.valid     = 1'b0;
    poll_ch.pin_level = 1'b0;
    poll_ch.now_ms    = '0;
    gaps_on           = 1'b1;
    tcur              = '0;
    cur_pin           = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values, active-low pin: pressed at the first poll, long press timed from zero
    send_poll(1'b0, 32'd5);
    send_poll(1'b0, 32'd400);
    send_poll(1'b0, 32'd1000);
    // release after a long press
    send_poll(1'b1, 32'd1010);
    send_poll(1'b1, 32'd1061);
    // short press with bounce on release, lands in the double click window
    send_poll(1'b0, 32'd1100);
    send_poll(1'b0, 32'd1151);
    send_poll(1'b1, 32'd1200);
    send_poll(1'b0, 32'd1202);
    send_poll(1'b1, 32'd1203);
    send_poll(1'b1, 32'd1260);
    // medium press gives only the release
    send_poll(1'b0, 32'd1700);
    send_poll(1'b0, 32'd1751);
    send_poll(1'b1, 32'd2400);
    send_poll(1'b1, 32'd2451);
    // plain click outside the double click window
    send_poll(1'b0, 32'd2460);
    send_poll(1'b0, 32'd2600);
    send_poll(1'b1, 32'd2700);
    send_poll(1'b1, 32'd2760);
    // timestamp wraps during the debounce of the press
    send_poll(1'b0, 32'hFFFF_FFE0);
    send_poll(1'b0, 32'h0000_0020);
    send_poll(1'b1, 32'h0000_0400);
    send_poll(1'b1, 32'h0000_0500);
    // zero long press time: press and long press from one poll
    drain();
    cfg_write(CFG_LONG_PRESS, 16'd0);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_poll(1'b0, 32'h0000_0600);
    send_poll(1'b0, 32'h0000_0700);
    send_poll(1'b1, 32'h0000_0710);
    send_poll(1'b1, 32'h0000_0800);

    // random phases over several register settings
    tcur = 32'h0000_1000;
    apply_config(1'b0, 5, 100, 40, 60, 1'b1, 1'b1);
    run_phase(POLLS_PER_PHASE, 60, 1'b0);
    apply_config(1'b1, 0, 0, 0, 0, 1'b1, 1'b1);
    run_phase(POLLS_PER_PHASE, 3, 1'b1);
    gaps_on = 1'b0;
    apply_config(1'b0, 65535, 65535, 65535, 65535, 1'b1, 1'b1);
    run_phase(POLLS_PER_PHASE, 32770, 1'b0);
    gaps_on = 1'b1;
    apply_config(1'b1, 3, 30, 20, 50, 1'b0, 1'b0);
    run_phase(POLLS_PER_PHASE, 25, 1'b0);
    for (p = 0; p < 4; p++) begin
      if (p == 3) begin
        deb = $urandom_range(0, 65535);
        lp  = $urandom_range(0, 65535);
        ck  = $urandom_range(0, 65535);
        dc  = $urandom_range(0, 65535);
      end else begin
        deb = $urandom_range(0, 20);
        lp  = $urandom_range(0, 300);
        ck  = $urandom_range(0, 200);
        dc  = $urandom_range(0, 300);
      end
      top_ms = deb;
      if (lp > top_ms) top_ms = lp;
      if (ck > top_ms) top_ms = ck;
      tcur += $urandom;
      apply_config(1'($urandom_range(0, 1)), deb, lp, ck, dc,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      gaps_on = (p != 1);
      run_phase(POLLS_PER_PHASE, top_ms / 2 + 2, p == 2);
    end
    gaps_on = 1'b1;

    drain();
    repeat (20) @(posedge clk);
    book.flag_leftovers();
    if (book.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
